// File: rtl/c2s_pkg.sv
// shared types and constants for the column to span converter
package c2s_pkg;

  // row bound with room for the empty marker and for one below row zero
  typedef logic signed [9:0] bound_t;

  localparam bound_t EMPTY_TOP = 10'sd255;

  typedef struct packed {
    logic load;
    logic setup;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

// File: rtl/c2s_ctrl.sv
// sequencer for the column to span converter
module c2s_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  c2s_pkg::sts_t sts,
  output c2s_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SETUP,
    RUN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !(state == IDLE || (state == RUN && !sts.busy));
  assign accept   = in_valid && !in_stall;

  assign cmd.load  = accept;
  assign cmd.setup = (state == SETUP);
  assign cmd.run   = (state == RUN);

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          state_next = SETUP;
        end
      end
      SETUP: begin
        state_next = RUN;
      end
      RUN: begin
        if (!sts.busy) begin
          state_next = accept ? SETUP : IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/c2s_datapath.sv
// row ranges, start column memory and span output register
module c2s_datapath #(
  parameter int ROWS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  c2s_pkg::cmd_t cmd,
  output c2s_pkg::sts_t sts,
  input  logic [9:0]    column,
  input  logic [5:0]    first_row,
  input  logic [5:0]    last_row,
  input  logic          plane_start,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [5:0]    span_row,
  output logic [9:0]    span_start,
  output logic [8:0]    span_end,
  output logic          span_last
);

  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [8:0] ROW_LIMIT = 9'(ROWS);

  logic [9:0] mem [ROWS];

  // per column
  logic [9:0]      col_q;
  logic [8:0]      end_q;
  c2s_pkg::bound_t t1;
  c2s_pkg::bound_t b1;
  c2s_pkg::bound_t t2;
  c2s_pkg::bound_t b2;

  // previous column
  logic [5:0] prev_first;
  logic [5:0] prev_last;
  logic       prev_empty;

  // close and open cursors
  logic [5:0] tc_row;
  logic [6:0] tc_cnt;
  logic [5:0] bc_row;
  logic [6:0] bc_cnt;
  logic [5:0] ot_row;
  logic [6:0] ot_cnt;
  logic [5:0] ob_row;
  logic [6:0] ob_cnt;

  logic            cur_empty;
  c2s_pkg::bound_t t1p;
  c2s_pkg::bound_t b1p;
  c2s_pkg::bound_t t2p;
  c2s_pkg::bound_t b2p;
  c2s_pkg::bound_t tc_diff;
  c2s_pkg::bound_t bc_diff;
  c2s_pkg::bound_t ot_diff;
  c2s_pkg::bound_t ob_diff;

  logic       out_free;
  logic       emit_en;
  logic       use_top;
  logic [5:0] emit_row;
  logic       emit_last;
  logic       wr_en;
  logic       wr_top;
  logic [5:0] wr_row;

  assign cur_empty = first_row > last_row;

  always_comb begin
    if (t1 < t2 && t1 <= b1) begin
      t1p = (t2 < b1 + 10'sd1) ? t2 : b1 + 10'sd1;
    end else begin
      t1p = t1;
    end
    if (b1 > b2 && b1 >= t1p) begin
      b1p = (b2 > t1p - 10'sd1) ? b2 : t1p - 10'sd1;
    end else begin
      b1p = b1;
    end
    if (t2 < t1p && t2 <= b2) begin
      t2p = (t1p < b2 + 10'sd1) ? t1p : b2 + 10'sd1;
    end else begin
      t2p = t2;
    end
    if (b2 > b1p && b2 >= t2p) begin
      b2p = (b1p > t2p - 10'sd1) ? b1p : t2p - 10'sd1;
    end else begin
      b2p = b2;
    end
    tc_diff = t1p - t1;
    bc_diff = b1 - b1p;
    ot_diff = t2p - t2;
    ob_diff = b2 - b2p;
  end

  assign sts.busy = (tc_cnt != 7'd0) || (bc_cnt != 7'd0) ||
                    (ot_cnt != 7'd0) || (ob_cnt != 7'd0);

  assign out_free  = !out_valid || !out_stall;
  assign use_top   = (tc_cnt != 7'd0);
  assign emit_en   = cmd.run && (use_top || bc_cnt != 7'd0) && out_free;
  assign emit_row  = use_top ? tc_row : bc_row;
  assign emit_last = use_top ? (tc_cnt == 7'd1 && bc_cnt == 7'd0) : (bc_cnt == 7'd1);

  assign wr_top = (ot_cnt != 7'd0);
  assign wr_en  = cmd.run && (wr_top || ob_cnt != 7'd0);
  assign wr_row = wr_top ? ot_row : ob_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= column;
      end_q <= 9'(column - 10'd1);
      if (plane_start || prev_empty) begin
        t1 <= c2s_pkg::EMPTY_TOP;
        b1 <= '0;
      end else begin
        t1 <= c2s_pkg::bound_t'({4'd0, prev_first});
        b1 <= c2s_pkg::bound_t'({4'd0, prev_last});
      end
      if (cur_empty) begin
        t2 <= c2s_pkg::EMPTY_TOP;
        b2 <= '0;
      end else begin
        t2 <= c2s_pkg::bound_t'({4'd0, first_row});
        b2 <= c2s_pkg::bound_t'({4'd0, last_row});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_first <= '0;
      prev_last  <= '0;
      prev_empty <= 1'b1;
    end else if (cmd.load) begin
      prev_first <= first_row;
      prev_last  <= last_row;
      prev_empty <= cur_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tc_cnt <= '0;
      bc_cnt <= '0;
      ot_cnt <= '0;
      ob_cnt <= '0;
    end else if (cmd.setup) begin
      tc_row <= t1[5:0];
      tc_cnt <= tc_diff[6:0];
      bc_row <= b1[5:0];
      bc_cnt <= bc_diff[6:0];
      ot_row <= t2[5:0];
      ot_cnt <= ot_diff[6:0];
      ob_row <= b2[5:0];
      ob_cnt <= ob_diff[6:0];
    end else begin
      if (emit_en) begin
        if (use_top) begin
          tc_row <= tc_row + 6'd1;
          tc_cnt <= tc_cnt - 7'd1;
        end else begin
          bc_row <= bc_row - 6'd1;
          bc_cnt <= bc_cnt - 7'd1;
        end
      end
      if (wr_en) begin
        if (wr_top) begin
          ot_row <= ot_row + 6'd1;
          ot_cnt <= ot_cnt - 7'd1;
        end else begin
          ob_row <= ob_row - 6'd1;
          ob_cnt <= ob_cnt - 7'd1;
        end
      end
    end
  end

  // start column write port
  always_ff @(posedge clk) begin
    if (wr_en && {3'd0, wr_row} < ROW_LIMIT) begin
      mem[ROW_AW'(wr_row)] <= col_q;
    end
  end

  // span word register, start column read straight into it
  always_ff @(posedge clk) begin
    if (emit_en) begin
      span_row  <= emit_row;
      span_end  <= end_q;
      span_last <= emit_last;
      if ({3'd0, emit_row} < ROW_LIMIT) begin
        span_start <= mem[ROW_AW'(emit_row)];
      end else begin
        span_start <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/column_to_span_converter.sv
// top level of the column to span converter
//
// input channel (in_valid, in_stall): one word per screen column, holding
// column, first_row, last_row and plane_start; first_row above last_row is
// an empty column, plane_start treats the previous column as empty.
// output channel (out_valid, out_stall): one word per closed row, holding
// span_row, span_start, span_end and span_last; span_last marks the final
// span of a column. the host ends a region with one empty column.
// a column is latched, then its row ranges are worked out; then one closed
// row is read from the start column memory per cycle while the output is
// not held by out_stall, and one opened row is written per cycle. the
// first span passes the column latch, the cursor registers and the span
// word register. when out_stall is high with a span waiting, the span word
// holds and the close sequence waits; the next column is taken as soon as
// the last span sits in the output register and every opened row is
// written. reset empties the output register, marks the previous column
// empty and leaves the start column memory as is.
module column_to_span_converter #(
  parameter int ROWS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] column,
  input  logic [5:0] first_row,
  input  logic [5:0] last_row,
  input  logic       plane_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] span_row,
  output logic [9:0] span_start,
  output logic [8:0] span_end,
  output logic       span_last
);

  c2s_pkg::cmd_t cmd;
  c2s_pkg::sts_t sts;

  c2s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  c2s_datapath #(
    .ROWS (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .column      (column),
    .first_row   (first_row),
    .last_row    (last_row),
    .plane_start (plane_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .span_row    (span_row),
    .span_start  (span_start),
    .span_end    (span_end),
    .span_last   (span_last)
  );

endmodule
